// ===== sv/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// Holds the request and response payload structs and the shared-unit operation codes.
// No dependencies.
`default_nettype none

package rau_pkg;

   // Operation selected by the request
   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_SUB = 2'd1,
      MODE_MUL = 2'd2,
      MODE_DIV = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [31:0] left_numerator;
      logic [30:0]        left_denominator;
      logic signed [31:0] right_numerator;
      logic [30:0]        right_denominator;
   } req_type;

   typedef struct packed {
      logic signed [63:0] whole_part;
      logic signed [31:0] frac_numerator;
      logic [62:0]        frac_denominator;
      logic               divide_by_zero;
   } rsp_type;

   // Operations of the shared arithmetic unit
   typedef enum logic [1:0] {
      ALU_MUL = 2'd0,
      ALU_DIV = 2'd1,
      ALU_GCD = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] q;
   } alu_req_type;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] q;
      logic        k_inc;
      logic        gcd_done;
   } alu_res_type;

   // Restoring division runs one quotient bit per step
   localparam logic [5:0] DIV_LAST = 6'd63;

   localparam logic [30:0] FRAC_MAX = 31'h7FFF_FFFF;

endpackage

`default_nettype wire

// ===== sv/rau_alu.sv =====
// Shared arithmetic unit: 32x32 multiply, one restoring-division step and
// one binary gcd step; division and gcd share a single 65-bit subtractor. Uses rau_pkg.
`default_nettype none

module rau_alu (
   input  wire rau_pkg::alu_req_type alu_req,
   output rau_pkg::alu_res_type      alu_res
);

   logic [63:0] product;
   logic [63:0] shifted;
   logic [64:0] minuend;
   logic [64:0] diff;
   logic        borrow;

   // Form the product and the one shared difference
   always_comb begin
      product = alu_req.a[31:0] * alu_req.b[31:0];
      shifted = {alu_req.a[62:0], alu_req.q[63]};
      minuend = (alu_req.op == rau_pkg::ALU_DIV) ? {1'b0, shifted} : {1'b0, alu_req.a};
      diff    = minuend - {1'b0, alu_req.b};
      borrow  = diff[64];
   end

   // Select the result of the requested operation
   always_comb begin
      alu_res.a        = alu_req.a;
      alu_res.b        = alu_req.b;
      alu_res.q        = alu_req.q;
      alu_res.k_inc    = 1'b0;
      alu_res.gcd_done = 1'b0;
      case (alu_req.op)
         rau_pkg::ALU_MUL: begin
            alu_res.a = product;
         end
         rau_pkg::ALU_DIV: begin
            alu_res.a = borrow ? shifted : diff[63:0];
            alu_res.q = {alu_req.q[62:0], ~borrow};
         end
         rau_pkg::ALU_GCD: begin
            if (alu_req.a == 64'd0 || alu_req.b == 64'd0) begin
               alu_res.gcd_done = 1'b1;
            end else if (!alu_req.a[0] && !alu_req.b[0]) begin
               alu_res.a     = alu_req.a >> 1;
               alu_res.b     = alu_req.b >> 1;
               alu_res.k_inc = 1'b1;
            end else if (!alu_req.a[0]) begin
               alu_res.a = alu_req.a >> 1;
            end else if (!alu_req.b[0]) begin
               alu_res.b = alu_req.b >> 1;
            end else if (borrow) begin
               // Swap so that the larger value sits in a
               alu_res.a = alu_req.b;
               alu_res.b = alu_req.a;
            end else begin
               alu_res.a = diff[63:0] >> 1;
            end
         end
         default: begin
            alu_res.a = alu_req.a;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: sequencer, operand registers and result register.
// Depends on rau_pkg and rau_alu.
//
// Usage:
//   The request channel (req_valid, req_ready, req_payload) carries two signed
//   fractions and an operation (add, subtract, multiply, divide). The response
//   channel (rsp_valid, rsp_ready, rsp_payload) returns one mixed number per
//   request: whole part truncated toward zero, reduced remainder and its
//   denominator, or the divide-by-zero flag with zero fields.
//   One request is worked on at a time; req_ready is high only while the
//   sequencer is idle. All work goes through one shared unit: binary gcd steps
//   (one subtract, shift or swap a cycle) on the denominators and on the
//   remainder, restoring divisions and 32x32 products. Add/subtract takes
//   2 gcds and 5 divisions, multiply/divide 1 gcd and 3 divisions; a zero
//   denominator or zero divisor skips the work and goes straight to the
//   output state. The next request can be taken in the cycle after the
//   result is written.
//   The result sits in an output register, so the next request is taken while
//   a result still waits; a stalled receiver holds the sequencer only when a
//   second result is ready to be written.
//   Reset (synchronous, active high) returns the sequencer to idle and drops
//   any pending response.
`default_nettype none

module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire rau_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output rau_pkg::rsp_type      rsp_payload
);

   localparam logic [30:0] DMASK = 31'((64'd1 << (OPERAND_WIDTH - 1)) - 64'd1);

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_GCD1 = 12'b0000_0000_0010,
      S_DIV1 = 12'b0000_0000_0100,
      S_DIV2 = 12'b0000_0000_1000,
      S_MUL  = 12'b0000_0001_0000,
      S_SUM  = 12'b0000_0010_0000,
      S_LOAD = 12'b0000_0100_0000,
      S_QUO  = 12'b0000_1000_0000,
      S_GCD2 = 12'b0001_0000_0000,
      S_DIV3 = 12'b0010_0000_0000,
      S_DIV4 = 12'b0100_0000_0000,
      S_OUT  = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   rau_pkg::mode_type  mode_ff, mode_in;
   logic [31:0]        n1mag_ff, n1mag_in, n2mag_ff, n2mag_in;
   logic               n1neg_ff, n1neg_in, n2neg_ff, n2neg_in;
   logic [30:0]        d1_ff, d1_in, d2_ff, d2_in;
   logic [30:0]        x1_ff, x1_in, x2_ff, x2_in;
   logic [63:0]        a_ff, a_in, b_ff, b_in, q_ff, q_in;
   logic [5:0]         k_ff, k_in, cnt_ff, cnt_in;
   logic [1:0]         mstep_ff, mstep_in;
   logic [63:0]        g_ff, g_in, p0_ff, p0_in, p1_ff, p1_in, den_ff, den_in;
   logic signed [63:0] num_ff, num_in;
   logic               numneg_ff, numneg_in;
   logic [63:0]        qmag_ff, qmag_in, rmag_ff, rmag_in;
   logic [63:0]        rred_ff, rred_in, dred_ff, dred_in;
   logic               err_ff, err_in;
   rau_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   rau_pkg::alu_req_type alu_req;
   rau_pkg::alu_res_type alu_res;

   logic signed [32:0] n1_ext, n2_ext, n1_abs, n2_abs;
   logic [30:0]        d1_m, d2_m;
   logic               req_err, req_addsub, cur_addsub, mul_last, div_last, rsp_load;
   logic [63:0]        gcd_val, t1, t2;
   logic signed [63:0] sum_val;
   logic [30:0]        frac_mag;
   rau_pkg::rsp_type   out_val;

   rau_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   // Cut the request operands to the configured width and sign-extend the numerators
   always_comb begin
      n1_ext = {{(33 - OPERAND_WIDTH){req_payload.left_numerator[OPERAND_WIDTH - 1]}},
                req_payload.left_numerator[OPERAND_WIDTH - 1:0]};
      n2_ext = {{(33 - OPERAND_WIDTH){req_payload.right_numerator[OPERAND_WIDTH - 1]}},
                req_payload.right_numerator[OPERAND_WIDTH - 1:0]};
      n1_abs = n1_ext[32] ? -n1_ext : n1_ext;
      n2_abs = n2_ext[32] ? -n2_ext : n2_ext;
      d1_m   = req_payload.left_denominator & DMASK;
      d2_m   = req_payload.right_denominator & DMASK;
      req_err = (d1_m == 31'd0) || (d2_m == 31'd0) ||
                (req_payload.mode == rau_pkg::MODE_DIV && n2_ext == 33'sd0);
      req_addsub = (req_payload.mode == rau_pkg::MODE_ADD) ||
                   (req_payload.mode == rau_pkg::MODE_SUB);
   end

   // Drive the shared unit
   always_comb begin
      cur_addsub = (mode_ff == rau_pkg::MODE_ADD) || (mode_ff == rau_pkg::MODE_SUB);
      mul_last   = cur_addsub ? (mstep_ff == 2'd2) : (mstep_ff == 2'd1);
      div_last   = (cnt_ff == rau_pkg::DIV_LAST);
      gcd_val    = (a_ff | b_ff) << k_ff;
      alu_req.op = rau_pkg::ALU_MUL;
      alu_req.a  = a_ff;
      alu_req.b  = b_ff;
      alu_req.q  = q_ff;
      case (state_ff)
         S_GCD1, S_GCD2: begin
            alu_req.op = rau_pkg::ALU_GCD;
         end
         S_DIV1, S_DIV2, S_QUO, S_DIV3, S_DIV4: begin
            alu_req.op = rau_pkg::ALU_DIV;
         end
         S_MUL: begin
            alu_req.op = rau_pkg::ALU_MUL;
            if (cur_addsub) begin
               case (mstep_ff)
                  2'd0: begin
                     alu_req.a = {32'd0, n1mag_ff};
                     alu_req.b = {33'd0, x2_ff};
                  end
                  2'd1: begin
                     alu_req.a = {32'd0, n2mag_ff};
                     alu_req.b = {33'd0, x1_ff};
                  end
                  default: begin
                     alu_req.a = {33'd0, x1_ff};
                     alu_req.b = {33'd0, d2_ff};
                  end
               endcase
            end else if (mstep_ff == 2'd0) begin
               alu_req.a = {32'd0, n1mag_ff};
               alu_req.b = (mode_ff == rau_pkg::MODE_MUL) ? {32'd0, n2mag_ff}
                                                           : {33'd0, d2_ff};
            end else begin
               alu_req.a = {33'd0, d1_ff};
               alu_req.b = (mode_ff == rau_pkg::MODE_MUL) ? {33'd0, d2_ff}
                                                           : {32'd0, n2mag_ff};
            end
         end
         default: begin
            alu_req.op = rau_pkg::ALU_MUL;
         end
      endcase
   end

   // Combine the signed products into the raw numerator
   always_comb begin
      t1 = n1neg_ff ? -p0_ff : p0_ff;
      t2 = (n2neg_ff ^ (mode_ff == rau_pkg::MODE_SUB)) ? -p1_ff : p1_ff;
      if (cur_addsub) begin
         sum_val = $signed(t1 + t2);
      end else begin
         sum_val = (n1neg_ff ^ n2neg_ff) ? $signed(-p0_ff) : $signed(p0_ff);
      end
   end

   // Assemble the response from the finished registers
   always_comb begin
      frac_mag = (rred_ff > {33'd0, rau_pkg::FRAC_MAX}) ? rau_pkg::FRAC_MAX : rred_ff[30:0];
      if (err_ff) begin
         out_val.whole_part       = 64'sd0;
         out_val.frac_numerator   = 32'sd0;
         out_val.frac_denominator = 63'd0;
         out_val.divide_by_zero   = 1'b1;
      end else begin
         out_val.whole_part       = numneg_ff ? $signed(-qmag_ff) : $signed(qmag_ff);
         out_val.frac_numerator   = numneg_ff ? $signed(-{1'b0, frac_mag})
                                              : $signed({1'b0, frac_mag});
         out_val.frac_denominator = dred_ff[62:0];
         out_val.divide_by_zero   = 1'b0;
      end
   end

   // Sequence the work through the shared unit
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      n1mag_in  = n1mag_ff;
      n2mag_in  = n2mag_ff;
      n1neg_in  = n1neg_ff;
      n2neg_in  = n2neg_ff;
      d1_in     = d1_ff;
      d2_in     = d2_ff;
      x1_in     = x1_ff;
      x2_in     = x2_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      q_in      = q_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      mstep_in  = mstep_ff;
      g_in      = g_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      numneg_in = numneg_ff;
      qmag_in   = qmag_ff;
      rmag_in   = rmag_ff;
      rred_in   = rred_ff;
      dred_in   = dred_ff;
      err_in    = err_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_payload.mode;
               n1mag_in = n1_abs[31:0];
               n2mag_in = n2_abs[31:0];
               n1neg_in = n1_ext[32];
               n2neg_in = n2_ext[32];
               d1_in    = d1_m;
               d2_in    = d2_m;
               err_in   = req_err;
               a_in     = {33'd0, d1_m};
               b_in     = {33'd0, d2_m};
               k_in     = 6'd0;
               mstep_in = 2'd0;
               if (req_err) begin
                  state_in = S_OUT;
               end else if (req_addsub) begin
                  state_in = S_GCD1;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_GCD1, S_GCD2: begin
            a_in = alu_res.a;
            b_in = alu_res.b;
            k_in = k_ff + 6'(alu_res.k_inc);
            if (alu_res.gcd_done) begin
               g_in   = gcd_val;
               b_in   = gcd_val;
               a_in   = 64'd0;
               cnt_in = 6'd0;
               if (state_ff == S_GCD1) begin
                  q_in     = {33'd0, d1_ff};
                  state_in = S_DIV1;
               end else begin
                  q_in     = rmag_ff;
                  state_in = S_DIV3;
               end
            end
         end
         S_DIV1: begin
            a_in   = alu_res.a;
            q_in   = alu_res.q;
            cnt_in = cnt_ff + 6'd1;
            if (div_last) begin
               x1_in    = alu_res.q[30:0];
               q_in     = {33'd0, d2_ff};
               a_in     = 64'd0;
               b_in     = g_ff;
               cnt_in   = 6'd0;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            a_in   = alu_res.a;
            q_in   = alu_res.q;
            cnt_in = cnt_ff + 6'd1;
            if (div_last) begin
               x2_in    = alu_res.q[30:0];
               mstep_in = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd0) begin
               p0_in = alu_res.a;
            end else if (mstep_ff == 2'd1 && cur_addsub) begin
               p1_in = alu_res.a;
            end else begin
               den_in = alu_res.a;
            end
            if (mul_last) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            num_in   = sum_val;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            numneg_in = num_ff[63];
            q_in      = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
            a_in      = 64'd0;
            b_in      = den_ff;
            cnt_in    = 6'd0;
            state_in  = S_QUO;
         end
         S_QUO: begin
            a_in   = alu_res.a;
            q_in   = alu_res.q;
            cnt_in = cnt_ff + 6'd1;
            if (div_last) begin
               qmag_in  = alu_res.q;
               rmag_in  = alu_res.a;
               a_in     = alu_res.a;
               b_in     = den_ff;
               k_in     = 6'd0;
               state_in = S_GCD2;
            end
         end
         S_DIV3: begin
            a_in   = alu_res.a;
            q_in   = alu_res.q;
            cnt_in = cnt_ff + 6'd1;
            if (div_last) begin
               rred_in  = alu_res.q;
               q_in     = den_ff;
               a_in     = 64'd0;
               b_in     = g_ff;
               cnt_in   = 6'd0;
               state_in = S_DIV4;
            end
         end
         S_DIV4: begin
            a_in   = alu_res.a;
            q_in   = alu_res.q;
            cnt_in = cnt_ff + 6'd1;
            if (div_last) begin
               dred_in  = alu_res.q;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);
      rsp_in       = rsp_load ? out_val : rsp_ff;
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Advance the operand and result registers
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      n1mag_ff  <= n1mag_in;
      n2mag_ff  <= n2mag_in;
      n1neg_ff  <= n1neg_in;
      n2neg_ff  <= n2neg_in;
      d1_ff     <= d1_in;
      d2_ff     <= d2_in;
      x1_ff     <= x1_in;
      x2_ff     <= x2_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      q_ff      <= q_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
      mstep_ff  <= mstep_in;
      g_ff      <= g_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      den_ff    <= den_in;
      num_ff    <= num_in;
      numneg_ff <= numneg_in;
      qmag_ff   <= qmag_in;
      rmag_ff   <= rmag_in;
      rred_ff   <= rred_in;
      dred_ff   <= dred_in;
      err_ff    <= err_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer still idle after taking a request");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.divide_by_zero) |->
         (rsp_payload.whole_part == 64'sd0 && rsp_payload.frac_numerator == 32'sd0 &&
          rsp_payload.frac_denominator == 63'd0))
      else $error("divide-by-zero response carries non-zero fields");

   a_denominator_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.divide_by_zero) |-> (rsp_payload.frac_denominator != 63'd0))
      else $error("valid result with zero denominator");

   a_sign_agrees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.divide_by_zero && rsp_payload.whole_part != 64'sd0 &&
       rsp_payload.frac_numerator != 32'sd0) |->
         (rsp_payload.whole_part[63] == rsp_payload.frac_numerator[31]))
      else $error("whole part and remainder disagree in sign");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_rational_arithmetic_unit.sv =====
// Self-checking testbench for the rational arithmetic unit.
// Drives a directed table and then random requests; results go against typed-in answers or a mixed-number predictor.
// Depends on rau_pkg and rational_arithmetic_unit.
`default_nettype none

module tb_rational_arithmetic_unit;

   typedef struct {
      rau_pkg::req_type request;
      bit               typed_in;
      rau_pkg::rsp_type answer;
   } table_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rau_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   rau_pkg::rsp_type rsp_payload;

   rau_pkg::rsp_type pending_results[$];
   table_row_type    directed_rows[$];
   int               mismatch_count;
   bit               sending_done;

   rational_arithmetic_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Euclid on unsigned 64-bit values
   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   // Work out the reduced mixed number for one request
   function automatic rau_pkg::rsp_type predict_mixed(rau_pkg::req_type r);
      logic [63:0]      d1, d2, cd, l, m, den, rmag, g;
      longint           n1, n2, num, whole, rem;
      bit               neg;
      rau_pkg::rsp_type o;
      o  = '0;
      n1 = r.left_numerator;
      n2 = r.right_numerator;
      d1 = {33'd0, r.left_denominator};
      d2 = {33'd0, r.right_denominator};
      if (d1 == 0 || d2 == 0 || (r.mode == rau_pkg::MODE_DIV && n2 == 0)) begin
         o.divide_by_zero = 1'b1;
         return o;
      end
      if (r.mode == rau_pkg::MODE_ADD || r.mode == rau_pkg::MODE_SUB) begin
         cd  = gcd64(d1, d2);
         l   = d1 / cd * d2;
         num = (r.mode == rau_pkg::MODE_ADD) ?
               n1 * longint'(l / d1) + n2 * longint'(l / d2) :
               n1 * longint'(l / d1) - n2 * longint'(l / d2);
         den = l;
      end else begin
         neg = (n1 < 0) != (n2 < 0);
         if (r.mode == rau_pkg::MODE_MUL) begin
            m   = magnitude(n1) * magnitude(n2);
            den = d1 * d2;
         end else begin
            m   = magnitude(n1) * d2;
            den = d1 * magnitude(n2);
         end
         num = neg ? -longint'(m) : longint'(m);
      end
      whole = num / longint'(den);
      rem   = num % longint'(den);
      rmag  = magnitude(rem);
      g     = gcd64(rmag, den);
      rmag  = rmag / g;
      den   = den / g;
      if (rmag > 64'(rau_pkg::FRAC_MAX))
         rmag = 64'(rau_pkg::FRAC_MAX);
      o.whole_part       = whole;
      o.frac_numerator   = (rem < 0) ? -32'(rmag) : 32'(rmag);
      o.frac_denominator = den[62:0];
      return o;
   endfunction

   function automatic rau_pkg::req_type pack_request(rau_pkg::mode_type md,
                                                     logic [31:0] n1, logic [30:0] d1,
                                                     logic [31:0] n2, logic [30:0] d2);
      rau_pkg::req_type r;
      r.mode              = md;
      r.left_numerator    = n1;
      r.left_denominator  = d1;
      r.right_numerator   = n2;
      r.right_denominator = d2;
      return r;
   endfunction

   function automatic void add_row(rau_pkg::req_type r, bit typed_in,
                                   rau_pkg::rsp_type answer);
      table_row_type row;
      row.request  = r;
      row.typed_in = typed_in;
      row.answer   = answer;
      directed_rows.push_back(row);
   endfunction

   // Random request: mostly small operands, some full range, a few zero denominators
   function automatic rau_pkg::req_type random_request();
      rau_pkg::req_type r;
      r.mode = rau_pkg::mode_type'($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) begin
         r.left_numerator    = $urandom;
         r.left_denominator  = 31'($urandom);
         r.right_numerator   = $urandom;
         r.right_denominator = 31'($urandom);
      end else begin
         r.left_numerator    = 32'($urandom_range(0, 400)) - 32'd200;
         r.left_denominator  = 31'($urandom_range(1, 120));
         r.right_numerator   = 32'($urandom_range(0, 400)) - 32'd200;
         r.right_denominator = 31'($urandom_range(1, 120));
      end
      if ($urandom_range(0, 40) == 0)
         r.left_denominator = '0;
      if ($urandom_range(0, 40) == 0)
         r.right_denominator = '0;
      if ($urandom_range(0, 25) == 0)
         r.right_numerator = '0;
      return r;
   endfunction

   // Offer one request and hold it until it is taken
   task automatic send_request(rau_pkg::req_type r, rau_pkg::rsp_type answer);
      req_valid   <= 1'b1;
      req_payload <= r;
      forever begin
         @(negedge clock);
         if (req_ready)
            break;
      end
      pending_results.push_back(answer);
      @(posedge clock);
   endtask

   // Sender: directed table, then random requests in bursts
   initial begin : sender
      int burst_left;
      int gap;
      rau_pkg::req_type r;
      rau_pkg::rsp_type err_rsp, zero_rsp, one_rsp;
      req_valid      = 1'b0;
      req_payload    = '0;
      reset          = 1'b1;
      sending_done   = 1'b0;
      mismatch_count = 0;
      err_rsp        = '0;
      err_rsp.divide_by_zero = 1'b1;
      zero_rsp       = '0;
      zero_rsp.frac_denominator = 63'd1;
      one_rsp        = zero_rsp;
      one_rsp.whole_part = 64'sd1;

      add_row(pack_request(rau_pkg::MODE_ADD, 32'sd0, 31'd1, 32'sd0, 31'd1), 1'b1, zero_rsp);
      add_row(pack_request(rau_pkg::MODE_ADD, 32'sd1, 31'd2, 32'sd1, 31'd2), 1'b1, one_rsp);
      add_row(pack_request(rau_pkg::MODE_DIV, 32'sd5, 31'd3, 32'sd0, 31'd7), 1'b1, err_rsp);
      add_row(pack_request(rau_pkg::MODE_ADD, 32'sd5, 31'd0, 32'sd1, 31'd7), 1'b1, err_rsp);
      add_row(pack_request(rau_pkg::MODE_MUL, 32'sd5, 31'd3, 32'sd1, 31'd0), 1'b1, err_rsp);
      add_row(pack_request(rau_pkg::MODE_SUB, 32'sd0, 31'd0, 32'sd0, 31'd0), 1'b1, err_rsp);
      add_row(pack_request(rau_pkg::MODE_MUL, 32'sd0, 31'h7FFF_FFFF, 32'sd9, 31'd4),
              1'b1, zero_rsp);
      add_row(pack_request(rau_pkg::MODE_SUB, 32'sd7, 31'd3, -32'sd7, 31'd6), 1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_MUL, -32'sd7, 31'd3, 32'sd5, 31'd4), 1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_DIV, 32'sd7, 31'd3, -32'sd5, 31'd4), 1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_ADD, 32'h8000_0000, 31'h7FFF_FFFF,
                           32'h7FFF_FFFF, 31'h7FFF_FFFE), 1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_SUB, 32'h8000_0000, 31'h7FFF_FFFF,
                           32'h7FFF_FFFF, 31'h7FFF_FFFE), 1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_MUL, 32'h8000_0000, 31'h7FFF_FFFF,
                           32'h8000_0000, 31'h7FFF_FFFE), 1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_DIV, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                           32'h8000_0000, 31'd1), 1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_DIV, 32'h8000_0000, 31'd1,
                           32'sd1, 31'h7FFF_FFFF), 1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_MUL, 32'sd3, 31'h7FFF_FFFF, 32'sd5, 31'h7FFF_FFFD),
              1'b0, '0);
      add_row(pack_request(rau_pkg::MODE_ADD, -32'sd1, 31'd1, 32'sd1, 31'd1), 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table back to back
      foreach (directed_rows[i])
         send_request(directed_rows[i].request, directed_rows[i].typed_in ?
                      directed_rows[i].answer : predict_mixed(directed_rows[i].request));

      burst_left = 0;
      repeat (600) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         r = random_request();
         send_request(r, predict_mixed(r));
      end
      req_valid    <= 1'b0;
      sending_done  = 1'b1;
   end

   // Receiver: one long hold-off early on, then randomly chosen stall patterns held for random spans
   initial begin : receiver
      int style;
      int span;
      rsp_ready = 1'b0;
      @(negedge reset);
      repeat (200) @(posedge clock);
      repeat (3000) @(posedge clock);
      forever begin
         style = $urandom_range(0, 2);
         span  = $urandom_range(50, 400);
         repeat (span) begin
            @(posedge clock);
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= ($urandom_range(0, 15) == 0);
            endcase
         end
      end
   end

   // Check each response against the oldest expectation
   always @(negedge clock) begin : response_check
      rau_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %h", rsp_payload);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.whole_part !== want.whole_part ||
                rsp_payload.frac_numerator !== want.frac_numerator ||
                rsp_payload.frac_denominator !== want.frac_denominator ||
                rsp_payload.divide_by_zero !== want.divide_by_zero) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d %0d/%0d dz=%b, got %0d %0d/%0d dz=%b",
                           want.whole_part, want.frac_numerator, want.frac_denominator,
                           want.divide_by_zero, rsp_payload.whole_part,
                           rsp_payload.frac_numerator, rsp_payload.frac_denominator,
                           rsp_payload.divide_by_zero);
            end
         end
      end
   end

   // Drain, allow a trailing window for stray responses, then report
   initial begin : finisher
      wait (sending_done);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (1000) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Hard stop if the block hangs
   initial begin : watchdog
      #200000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== rational_arithmetic_unit.f =====
sv/rau_pkg.sv
sv/rau_alu.sv
sv/rational_arithmetic_unit.sv
dv/tb_rational_arithmetic_unit.sv
